// ----- rtl/ctl_pkg.sv -----
// ctl_pkg: shared constants and types for the cache tag lookup block
// no dependencies
`timescale 1ns / 1ps
package ctl_pkg;
	localparam int MAX_SETS = 256;
	localparam int MAX_WAYS = 8;
	localparam int SET_W = $clog2(MAX_SETS);
	localparam int WAY_W = $clog2(MAX_WAYS);
	localparam int MAXSB = $clog2(MAX_SETS);
	localparam int ROW_W = MAX_WAYS * 32;
	localparam int RANK_W = MAX_WAYS * 3;
	localparam int STATE_W = MAX_WAYS + WAY_W;
	localparam int QDEPTH = 2;

	localparam logic [1:0] REG_OFFSET = 2'd0;
	localparam logic [1:0] REG_SETS = 2'd1;
	localparam logic [1:0] REG_WAYS = 2'd2;
	localparam logic [1:0] REG_LRU = 2'd3;

	typedef struct packed {
		logic [SET_W-1:0] set;
		logic [31:0] tag;
		logic [3:0] ways;
		logic lru;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [2:0] way;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
	} res_t;
endpackage

// ----- rtl/ctl_ram.sv -----
// ctl_ram: generic single-port-write, one-port-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module ctl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/ctl_front.sv -----
// ctl_front: splits the address into set and tag and queues the request
// depends on ctl_pkg
`timescale 1ns / 1ps
module ctl_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [31:0] address,
	input logic [4:0] offset_bits,
	input logic [3:0] set_bits,
	input logic [3:0] ways_in_use,
	input logic replace_lru,
	output logic req_valid,
	output ctl_pkg::req_t req,
	input logic req_take
);
	ctl_pkg::req_t q_q [ctl_pkg::QDEPTH];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic [31:0] line, tag;
	logic [3:0] sb, w;
	ctl_pkg::req_t nr;
	logic do_push;

	always_comb begin
		line = address >> offset_bits;
		sb = (set_bits > 4'(ctl_pkg::MAXSB)) ? 4'(ctl_pkg::MAXSB) : set_bits;
		w = (ways_in_use == 4'd0) ? 4'd1 :
			(ways_in_use > 4'(ctl_pkg::MAX_WAYS)) ? 4'(ctl_pkg::MAX_WAYS) : ways_in_use;
		tag = line >> sb;
		nr.set = ctl_pkg::SET_W'(line & ~(32'hffffffff << sb));
		nr.tag = tag;
		nr.ways = w;
		nr.lru = replace_lru;
	end

	assign full = (cnt_q == 2'(ctl_pkg::QDEPTH));
	assign do_push = push && !full;
	assign req_valid = (cnt_q != 2'd0);
	assign req = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) q_q[wr_q] <= nr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (req_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(req_take);
		end
	end
endmodule

// ----- rtl/ctl_back.sv -----
// ctl_back: set read, compare, replacement and write-back; one result register
// depends on ctl_pkg, ctl_ram
`timescale 1ns / 1ps
module ctl_back (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input ctl_pkg::req_t req,
	output logic req_take,
	output logic empty,
	input logic pop,
	output ctl_pkg::res_t res
);
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_LOOK = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t st_q;
	ctl_pkg::req_t r_q;
	logic [ctl_pkg::ROW_W-1:0] tag_rd, tag_wr;
	logic [ctl_pkg::RANK_W-1:0] rank_rd, rank_wr, rank_wd;
	logic [ctl_pkg::STATE_W-1:0] st_rd, st_wd;
	logic [ctl_pkg::SET_W-1:0] clr_q, wa;
	logic clearing, we_tag, we_row;
	logic [31:0] hits_q, miss_q;
	logic out_full_q;
	ctl_pkg::res_t out_q;
	logic [ctl_pkg::MAX_WAYS-1:0] vrow, vnew;
	logic hit, found;
	logic [2:0] way;
	logic [2:0] best;
	logic [2:0] old, rk;
	logic [ctl_pkg::WAY_W-1:0] fp, fp_new;

	// valid bits and fill pointer of a set share one row
	ctl_ram #(.WIDTH(ctl_pkg::ROW_W), .DEPTH(ctl_pkg::MAX_SETS)) u_tag (
		.clk(clk), .we(we_tag), .waddr(r_q.set), .wdata(tag_wr),
		.raddr(req.set), .rdata(tag_rd)
	);
	ctl_ram #(.WIDTH(ctl_pkg::RANK_W), .DEPTH(ctl_pkg::MAX_SETS)) u_rank (
		.clk(clk), .we(we_row), .waddr(wa), .wdata(rank_wd),
		.raddr(req.set), .rdata(rank_rd)
	);
	ctl_ram #(.WIDTH(ctl_pkg::STATE_W), .DEPTH(ctl_pkg::MAX_SETS)) u_state (
		.clk(clk), .we(we_row), .waddr(wa), .wdata(st_wd),
		.raddr(req.set), .rdata(st_rd)
	);

	assign clearing = (st_q == ST_CLEAR);
	assign req_take = (st_q == ST_IDLE) && req_valid && (!out_full_q || pop);
	assign we_tag = (st_q == ST_LOOK);
	assign we_row = we_tag || clearing;
	assign wa = clearing ? clr_q : r_q.set;
	assign rank_wd = clearing ? '0 : rank_wr;
	assign st_wd = clearing ? '0 : {fp_new, vnew};
	assign empty = !out_full_q;
	assign res = out_q;

	always_comb begin
		vrow = st_rd[ctl_pkg::MAX_WAYS-1:0];
		fp = st_rd[ctl_pkg::STATE_W-1 -: ctl_pkg::WAY_W];
		hit = 1'b0;
		found = 1'b0;
		way = '0;
		best = '0;
		rk = '0;
		for (int i = ctl_pkg::MAX_WAYS - 1; i >= 0; i--) begin
			if (4'(i) < r_q.ways && vrow[i] && tag_rd[i*32 +: 32] == r_q.tag) begin
				hit = 1'b1;
				way = 3'(i);
			end
		end
		if (!hit) begin
			for (int i = ctl_pkg::MAX_WAYS - 1; i >= 0; i--) begin
				if (4'(i) < r_q.ways && !vrow[i]) begin
					found = 1'b1;
					way = 3'(i);
				end
			end
			if (!found) begin
				if (r_q.lru) begin
					way = '0;
					for (int i = 0; i < ctl_pkg::MAX_WAYS; i++) begin
						if (4'(i) < r_q.ways && rank_rd[i*3 +: 3] > best) begin
							best = rank_rd[i*3 +: 3];
							way = 3'(i);
						end
					end
				end else begin
					way = ({1'b0, fp} < r_q.ways) ? fp : 3'd0;
				end
			end
		end
		old = rank_rd[way*3 +: 3];
		tag_wr = tag_rd;
		rank_wr = rank_rd;
		vnew = vrow;
		fp_new = fp;
		if (!hit) begin
			tag_wr[way*32 +: 32] = r_q.tag;
			vnew[way] = 1'b1;
		end
		if (!hit && !found && !r_q.lru) begin
			fp_new = (4'(way) + 4'd1 < r_q.ways) ? way + 3'd1 : 3'd0;
		end
		if (!hit || r_q.lru) begin
			for (int i = 0; i < ctl_pkg::MAX_WAYS; i++) begin
				rk = rank_rd[i*3 +: 3];
				if (4'(i) < r_q.ways && 3'(i) != way && vrow[i] && (!hit || rk < old)
					&& rk != 3'd7)
					rank_wr[i*3 +: 3] = rk + 3'd1;
			end
			rank_wr[way*3 +: 3] = 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) r_q <= req;
		if (we_tag) begin
			out_q.hit <= hit;
			out_q.way <= way;
			out_q.hit_count <= (hit && hits_q != '1) ? hits_q + 32'd1 : hits_q;
			out_q.miss_count <= (!hit && miss_q != '1) ? miss_q + 32'd1 : miss_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (pop && out_full_q) out_full_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_take) st_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (hit && hits_q != '1) hits_q <= hits_q + 32'd1;
					if (!hit && miss_q != '1) miss_q <= miss_q + 32'd1;
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					out_full_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/cache_tag_lookup_fifo_lru.sv -----
// cache_tag_lookup_fifo_lru: top level, config registers, front and back parts
// depends on ctl_pkg, ctl_front, ctl_back, ctl_ram
//
// channel  dir  handshake      payload
// in       in   push / full    address
// out      out  empty / pop    hit, way, hit_count, miss_count
// cfg      in   wr_en          wr_index, wr_data
//
// the back part finishes one item before it takes the next, and stalls while the
// result register is full: lookup read, compare and write-back, then result
// hand-off, a read-modify-write of one set row. the front queue holds two items.
// after arst_n the back part clears valid bits, fill pointers and ranks in a
// pass over all 256 sets before the first lookup; tag memory needs no clear.
// a full result register stalls the back part; the front keeps accepting until full.
`timescale 1ns / 1ps
module cache_tag_lookup_fifo_lru (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [31:0] address,
	output logic empty,
	input logic pop,
	output logic hit,
	output logic [2:0] way,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count,
	input logic wr_en,
	input logic [1:0] wr_index,
	input logic [4:0] wr_data
);
	logic [4:0] offset_bits_q;
	logic [3:0] set_bits_q, ways_q;
	logic lru_q;
	logic req_valid, req_take, back_empty, back_pop;
	ctl_pkg::req_t req;
	ctl_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 5'd6;
			set_bits_q <= 4'd0;
			ways_q <= 4'd1;
			lru_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				ctl_pkg::REG_OFFSET: offset_bits_q <= wr_data;
				ctl_pkg::REG_SETS: set_bits_q <= wr_data[3:0];
				ctl_pkg::REG_WAYS: ways_q <= wr_data[3:0];
				ctl_pkg::REG_LRU: lru_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	ctl_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .address(address),
		.offset_bits(offset_bits_q), .set_bits(set_bits_q), .ways_in_use(ways_q),
		.replace_lru(lru_q), .req_valid(req_valid), .req(req), .req_take(req_take)
	);

	assign back_pop = pop;
	ctl_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req(req),
		.req_take(req_take), .empty(back_empty), .pop(back_pop), .res(res)
	);

	assign empty = back_empty;
	assign hit = res.hit;
	assign way = res.way;
	assign hit_count = res.hit_count;
	assign miss_count = res.miss_count;

	a_hit_way: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && hit |-> {1'b0, way} < ways_q || ways_q == 4'd0 || ways_q > 4'd8)
		else $error("hit way out of range");
	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty |=> empty) else $error("result not removed");
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && $past(!empty) && !$past(pop) |-> $stable(hit_count))
		else $error("count changed while held");
endmodule
